>>> sv/sbdb_pkg.sv
// Shared constants, register map and log table for the spectrum bar level block.
package sbdb_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int NUM_BARS_DEF = 32;
  localparam int SUM_W        = 54;
  localparam int SQ_W         = 2 * SAMPLE_BITS;
  localparam int BPB_W        = 7;
  localparam int OFFSET_W     = 16;
  localparam int IDX_W        = 5;
  localparam int LEVEL_W      = 7;
  localparam int POS_W        = 6;
  localparam int FRAC_W       = 6;
  localparam int DB_W         = 16;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [LEVEL_W-1:0]  LEVEL_TOP      = 7'd78;
  localparam logic [DB_W-1:0]     DB_PER_OCTAVE  = 16'd771;   // 10*log10(2) in Q8
  localparam logic [BPB_W-1:0]    BPB_RESET      = 7'd4;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET   = 16'hC0A7;  // -16217

  // register indexes, taken from paddr[2]
  localparam logic REG_BINS_PER_BAR = 1'b0;
  localparam logic REG_LEVEL_OFFSET = 1'b1;

  // round(2560*log10(1 + f/64)), Q8 dB of the mantissa
  localparam logic [9:0] FRAC_DB_Q8 [64] = '{
    10'd0,   10'd17,  10'd34,  10'd51,  10'd67,  10'd84,  10'd100, 10'd115,
    10'd131, 10'd146, 10'd161, 10'd176, 10'd191, 10'd206, 10'd220, 10'd234,
    10'd248, 10'd262, 10'd276, 10'd289, 10'd302, 10'd315, 10'd328, 10'd341,
    10'd354, 10'd367, 10'd379, 10'd391, 10'd403, 10'd415, 10'd427, 10'd439,
    10'd451, 10'd462, 10'd474, 10'd485, 10'd496, 10'd507, 10'd518, 10'd529,
    10'd540, 10'd550, 10'd561, 10'd571, 10'd582, 10'd592, 10'd602, 10'd612,
    10'd622, 10'd632, 10'd642, 10'd652, 10'd661, 10'd671, 10'd680, 10'd690,
    10'd699, 10'd708, 10'd717, 10'd726, 10'd735, 10'd744, 10'd753, 10'd762
  };

endpackage

>>> sv/sbdb_if.sv
// Valid/ready channels for FFT bins in and bar levels out.
interface sbdb_bin_if import sbdb_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] bin_real;
  logic signed [SAMPLE_BITS-1:0] bin_imag;
  logic                          last_bin;

  modport source (output valid, bin_real, bin_imag, last_bin, input ready);
  modport sink   (input valid, bin_real, bin_imag, last_bin, output ready);
endinterface

interface sbdb_bar_if import sbdb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   bar_index;
  logic [LEVEL_W-1:0] bar_level;
  logic               last_bar;

  modport source (output valid, bar_index, bar_level, last_bar, input ready);
  modport sink   (input valid, bar_index, bar_level, last_bar, output ready);
endinterface

>>> sv/spectrum_bins_to_db_bars.sv
// Spectrum bar levels: sums bin power over groups of bins and gives one dB level per group.
// Takes one FFT bin per cycle when not stalled and runs it through five register stages:
// input register, squaring, power accumulation and bar emission, leading-one search, and
// the dB/clamp arithmetic into the output register. Bins keep flowing while a finished bar
// waits at the output, until the stages behind it fill. A last_bin that closes a frame before
// all NUM_BARS bars are out makes the bar emitter send zero-level bars for the rest, one per
// cycle while stage 3 can advance; no bin is taken from the squaring stage meanwhile.
// Configuration is written over the APB-style port (bins_per_bar at 0x0, level_offset_q8 at
// 0x4); the user must write it only while no bin is in flight, the block does not enforce it.
module spectrum_bins_to_db_bars import sbdb_pkg::*; #(
  parameter int NUM_BARS = NUM_BARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sbdb_bin_if.sink              in_bin,
  sbdb_bar_if.source            out_bar,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int BW = $clog2(NUM_BARS + 1);
  localparam logic [BW-1:0] NUM_BARS_C = BW'(NUM_BARS);
  localparam logic [BW-1:0] LAST_IDX_C = BW'(NUM_BARS - 1);

  // ---------------- configuration ----------------
  logic [BPB_W-1:0]    bpb_r;
  logic [OFFSET_W-1:0] offset_r;
  logic                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpb_r    <= BPB_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_BINS_PER_BAR: bpb_r    <= cfg_pwdata[BPB_W-1:0];
        REG_LEVEL_OFFSET: offset_r <= cfg_pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_BINS_PER_BAR: cfg_prdata = CFG_DATA_W'(bpb_r);
      REG_LEVEL_OFFSET: cfg_prdata = CFG_DATA_W'(signed'(offset_r));
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------- stage handshakes ----------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic take1, take2, fill_r;

  assign rdy5  = !out_valid_r || out_bar.ready;
  assign rdy4  = !v4_r || rdy5;
  assign rdy3  = !v3_r || rdy4;
  assign take2 = v2_r && !fill_r && rdy3;
  assign rdy2  = !v2_r || take2;
  assign take1 = v1_r && rdy2;
  assign rdy1  = !v1_r || take1;

  assign in_bin.ready = rdy1;

  // ---------------- stage 1: input register ----------------
  logic signed [SAMPLE_BITS-1:0] re1_r, im1_r;
  logic                          last1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_bin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bin.valid && rdy1) begin
      re1_r   <= in_bin.bin_real;
      im1_r   <= in_bin.bin_imag;
      last1_r <= in_bin.last_bin;
    end
  end

  // ---------------- stage 2: squares ----------------
  // a signed square equals the square of the magnitude, most negative value included
  logic signed [SQ_W-1:0] sq_re, sq_im;
  logic [SQ_W-1:0]        p2_r, q2_r;
  logic                   last2_r;

  assign sq_re = re1_r * re1_r;
  assign sq_im = im1_r * im1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= take1;
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      p2_r    <= unsigned'(sq_re);
      q2_r    <= unsigned'(sq_im);
      last2_r <= last1_r;
    end
  end

  // ---------------- stage 3: accumulate and emit ----------------
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [BPB_W-1:0] bins_r, bins_nxt;
  logic [BW-1:0]    bars_r, bars_nxt;
  logic             fill_nxt;
  logic [SUM_W-1:0] sum3_r, sum3_nxt;
  logic [BW-1:0]    idx3_r, idx3_nxt;
  logic             zero3_r, zero3_nxt;
  logic             load3;

  logic             active, emit;
  logic [BPB_W-1:0] width, bins_inc;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic [BW-1:0]    bars_after;

  assign active   = bars_r < NUM_BARS_C;
  assign width    = (bpb_r == '0) ? BPB_W'(1) : bpb_r;
  assign bins_inc = bins_r + BPB_W'(1);
  assign sum_add  = {1'b0, sum_r} + (SUM_W+1)'(p2_r) + (SUM_W+1)'(q2_r);
  assign sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign emit     = active && ((bins_inc >= width) || last2_r);

  always_comb begin
    sum_nxt    = sum_r;
    bins_nxt   = bins_r;
    bars_nxt   = bars_r;
    fill_nxt   = fill_r;
    sum3_nxt   = sum3_r;
    idx3_nxt   = idx3_r;
    zero3_nxt  = zero3_r;
    load3      = 1'b0;
    bars_after = bars_r;
    priority if (fill_r && rdy3) begin
      // closing an early frame: one zero bar per cycle while stage 3 can advance
      load3     = 1'b1;
      idx3_nxt  = bars_r;
      zero3_nxt = 1'b1;
      if (bars_r == LAST_IDX_C) begin
        fill_nxt = 1'b0;
        bars_nxt = '0;
      end else begin
        bars_nxt = bars_r + BW'(1);
      end
    end else if (take2) begin
      if (active) begin
        if (emit) begin
          load3      = 1'b1;
          sum3_nxt   = sum_sat;
          idx3_nxt   = bars_r;
          zero3_nxt  = 1'b0;
          bars_after = bars_r + BW'(1);
          bars_nxt   = bars_after;
          sum_nxt    = '0;
          bins_nxt   = '0;
        end else begin
          sum_nxt  = sum_sat;
          bins_nxt = bins_inc;
        end
      end
      if (last2_r) begin
        sum_nxt  = '0;
        bins_nxt = '0;
        if (bars_after < NUM_BARS_C) begin
          fill_nxt = 1'b1;
          bars_nxt = bars_after;
        end else begin
          bars_nxt = '0;
        end
      end
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      bins_r <= '0;
      bars_r <= '0;
      fill_r <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      bins_r <= bins_nxt;
      bars_r <= bars_nxt;
      fill_r <= fill_nxt;
      if (rdy3) begin
        v3_r <= load3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      sum3_r  <= sum3_nxt;
      idx3_r  <= idx3_nxt;
      zero3_r <= zero3_nxt;
    end
  end

  // ---------------- stage 4: leading one and mantissa ----------------
  logic [POS_W-1:0]  lead_pos;
  logic [SUM_W-1:0]  norm;
  logic [POS_W-1:0]  m4_r;
  logic [FRAC_W-1:0] f4_r;
  logic              zero4_r;
  logic [BW-1:0]     idx4_r;

  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (sum3_r[i]) lead_pos = POS_W'(i);
    end
  end

  // leading one moved to the top bit; the six bits under it index the table
  assign norm = sum3_r << (POS_W'(SUM_W - 1) - lead_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && rdy4) begin
      m4_r    <= lead_pos;
      f4_r    <= norm[SUM_W-2 -: FRAC_W];
      zero4_r <= zero3_r || (sum3_r == '0);
      idx4_r  <= idx3_r;
    end
  end

  // ---------------- stage 5: dB, offset, clamp ----------------
  logic [DB_W-1:0]        db_q8;
  logic signed [DB_W+1:0] lvl_q8;
  logic [DB_W+1:0]        neg_q8;
  logic [DB_W-7:0]        below;   // whole dB below the top, truncated toward zero
  logic [LEVEL_W-1:0]     level;
  logic [BW+IDX_W-1:0]    idx_ext;

  logic [IDX_W-1:0]   out_idx_r;
  logic [LEVEL_W-1:0] out_lvl_r;
  logic               out_last_r;

  assign db_q8   = DB_W'(DB_W'(m4_r) * DB_PER_OCTAVE) + DB_W'(FRAC_DB_Q8[f4_r]);
  assign lvl_q8  = signed'({2'b00, db_q8}) + (DB_W+2)'(signed'(offset_r));
  assign neg_q8  = unsigned'(-lvl_q8);
  assign below   = neg_q8[DB_W+1:8];
  assign idx_ext = {{IDX_W{1'b0}}, idx4_r};

  always_comb begin
    priority if (zero4_r) begin
      level = '0;
    end else if (!lvl_q8[DB_W+1]) begin
      level = LEVEL_TOP;
    end else if (below >= (DB_W-6)'(LEVEL_TOP)) begin
      level = '0;
    end else begin
      level = LEVEL_TOP - LEVEL_W'(below);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy5) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && rdy5) begin
      out_idx_r  <= idx_ext[IDX_W-1:0];
      out_lvl_r  <= level;
      out_last_r <= (idx4_r == LAST_IDX_C);
    end
  end

  assign out_bar.valid     = out_valid_r;
  assign out_bar.bar_index = out_idx_r;
  assign out_bar.bar_level = out_lvl_r;
  assign out_bar.last_bar  = out_last_r;

  // ---------------- checks ----------------
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r |-> (bars_r < NUM_BARS_C))
    else $error("zero-bar fill running past the last bar");

  a_no_take_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r |-> !take2)
    else $error("bin consumed while zero bars are being sent");

  a_group_only_open: assert property (@(posedge clk) disable iff (!rst_n)
    (bins_r != '0) |-> (bars_r < NUM_BARS_C))
    else $error("partial group held in a full frame");

  a_fill_starts_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fill_r) |-> $past(take2 && last2_r))
    else $error("zero-bar fill without a last bin");

endmodule

>>> sim/spectrum_bins_to_db_bars_tb.sv
// Self-checking testbench for the spectrum bar level block: bins in, dB bar levels out.
module spectrum_bins_to_db_bars_tb;
  import sbdb_pkg::*;

  localparam int BAR_COUNT          = NUM_BARS_DEF;
  localparam int LEVEL_MAX          = 78;
  localparam int OCTAVE_DB_Q8       = 771;
  localparam int SAMPLE_MIN         = -(1 << (SAMPLE_BITS - 1));
  localparam int SAMPLE_MAX         = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int BPB_AFTER_RESET    = 4;
  localparam int OFFSET_AFTER_RESET = -16217;
  localparam int WATCHDOG_LIMIT     = 1000;
  localparam int DRAIN_CYCLES       = 20;
  localparam int RANDOM_ITEMS       = 180;
  localparam logic [SUM_W-1:0] SUM_SAT = '1;

  // Q8 dB of the 6-bit mantissa below the leading one
  localparam int MANT_DB_Q8 [64] = '{
      0,  17,  34,  51,  67,  84, 100, 115, 131, 146, 161, 176, 191, 206, 220, 234,
    248, 262, 276, 289, 302, 315, 328, 341, 354, 367, 379, 391, 403, 415, 427, 439,
    451, 462, 474, 485, 496, 507, 518, 529, 540, 550, 561, 571, 582, 592, 602, 612,
    622, 632, 642, 652, 661, 671, 680, 690, 699, 708, 717, 726, 735, 744, 753, 762
  };

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          last;
  } bin_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } bar_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sbdb_bin_if bin_ch ();
  sbdb_bar_if bar_ch ();

  spectrum_bins_to_db_bars dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bin      (bin_ch.sink),
    .out_bar     (bar_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor state and configuration
  logic [BPB_W-1:0]           cur_bins_per_bar;
  logic signed [OFFSET_W-1:0] cur_offset;
  logic [SUM_W-1:0]           acc_power;
  int                         acc_bins;
  int                         bars_out;

  bar_t bars_due [$];
  int   n_fail      = 0;
  int   random_sent = 0;
  int   idle_cycles = 0;
  bit   steady      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CFG_ADDR_W-1:0] reg_addr(input logic idx);
    return CFG_ADDR_W'({idx, 2'b00});
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] bin_magnitude(input logic signed [SAMPLE_BITS-1:0] x);
    logic signed [SAMPLE_BITS:0] w;
    w = x;
    if (w < 0) w = -w;
    return w[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [LEVEL_W-1:0] db_bar_level(input logic [SUM_W-1:0] s);
    int msb;
    int frac;
    int v;
    if (s == '0) return '0;
    msb = 0;
    for (int k = 0; k < SUM_W; k++) if (s[k]) msb = k;
    if (msb >= 6) frac = int'((s >> (msb - 6)) & 63);
    else frac = int'((s << (6 - msb)) & 63);
    v = msb * OCTAVE_DB_Q8 + MANT_DB_Q8[frac] + int'(cur_offset);
    // int division truncates toward zero
    v = LEVEL_MAX + v / 256;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    if (v < 0) v = 0;
    return LEVEL_W'(v);
  endfunction

  function automatic bar_t bar_of(input int idx, input logic [LEVEL_W-1:0] level);
    bar_t r;
    r.idx   = IDX_W'(idx);
    r.level = level;
    r.last  = (idx == BAR_COUNT - 1);
    return r;
  endfunction

  task automatic predict_bars(input bin_t b);
    logic [SQ_W-1:0]  p;
    logic [SQ_W-1:0]  q;
    logic [SQ_W:0]    pw;
    logic [SUM_W:0]   nxt;
    logic [SAMPLE_BITS-1:0] re_m;
    logic [SAMPLE_BITS-1:0] im_m;
    int width;
    width = (cur_bins_per_bar == '0) ? 1 : int'(cur_bins_per_bar);
    if (bars_out < BAR_COUNT) begin
      re_m = bin_magnitude(b.re);
      im_m = bin_magnitude(b.im);
      p    = re_m * re_m;
      q    = im_m * im_m;
      pw   = p + q;
      nxt  = acc_power + pw;
      acc_power = (nxt > SUM_SAT) ? SUM_SAT : nxt[SUM_W-1:0];
      acc_bins++;
      if (acc_bins >= width || b.last) begin
        bars_due.push_back(bar_of(bars_out, db_bar_level(acc_power)));
        bars_out++;
        acc_power = '0;
        acc_bins  = 0;
      end
    end
    if (b.last) begin
      // early end of frame: pad with zero-level bars
      while (bars_out < BAR_COUNT) begin
        bars_due.push_back(bar_of(bars_out, '0));
        bars_out++;
      end
      acc_power = '0;
      acc_bins  = 0;
      bars_out  = 0;
    end
  endtask

  function automatic bin_t bin_of(input int re, input int im, input bit last);
    bin_t b;
    b.re   = re[SAMPLE_BITS-1:0];
    b.im   = im[SAMPLE_BITS-1:0];
    b.last = last;
    return b;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    logic signed [SAMPLE_BITS-1:0] r;
    case ($urandom_range(0, 7))
      0: r = SAMPLE_BITS'(SAMPLE_MIN);
      1: r = SAMPLE_BITS'(SAMPLE_MAX);
      2: r = '0;
      default: begin
        r = SAMPLE_BITS'($urandom());
        r = r >>> $urandom_range(0, SAMPLE_BITS - 1);
      end
    endcase
    return r;
  endfunction

  function automatic bin_t random_bin(input bit last);
    bin_t b;
    b.re   = random_sample();
    b.im   = random_sample();
    b.last = last;
    return b;
  endfunction

  task automatic send_bin(input bin_t b);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 8) begin
      bin_ch.valid <= 1'b0;
      @(negedge clk);
    end
    bin_ch.valid    <= 1'b1;
    bin_ch.bin_real <= b.re;
    bin_ch.bin_imag <= b.im;
    bin_ch.last_bin <= b.last;
    do @(posedge clk); while (bin_ch.ready !== 1'b1);
    predict_bars(b);
  endtask

  task automatic bins_idle();
    @(negedge clk);
    bin_ch.valid <= 1'b0;
  endtask

  task automatic wait_bars_drained();
    while (bars_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= reg_addr(idx);
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (idx == REG_BINS_PER_BAR) cur_bins_per_bar = data[BPB_W-1:0];
    else cur_offset = data[OFFSET_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(input logic idx, output logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= reg_addr(idx);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_registers();
    logic [CFG_DATA_W-1:0] rd;
    cfg_read(REG_BINS_PER_BAR, rd);
    if (rd[BPB_W-1:0] !== cur_bins_per_bar) begin
      $error("bins_per_bar: expected %0d, got %0d", cur_bins_per_bar, rd[BPB_W-1:0]);
      n_fail++;
    end
    cfg_read(REG_LEVEL_OFFSET, rd);
    if (rd[OFFSET_W-1:0] !== cur_offset) begin
      $error("level_offset_q8: expected %0d, got %0d", cur_offset,
             $signed(rd[OFFSET_W-1:0]));
      n_fail++;
    end
  endtask

  // only touch registers once the pipe is empty
  task automatic set_levels(input logic [BPB_W-1:0] bpb, input logic signed [OFFSET_W-1:0] offset);
    bins_idle();
    wait_bars_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(REG_BINS_PER_BAR, CFG_DATA_W'(bpb));
    cfg_write(REG_LEVEL_OFFSET, {{(CFG_DATA_W - OFFSET_W){1'b0}}, offset});
    check_registers();
  endtask

  task automatic test_register_defaults();
    check_registers();
  endtask

  task automatic test_directed_bins();
    set_levels(7'd1, 16'(OFFSET_AFTER_RESET));
    send_bin(bin_of(0, 0, 1'b0));
    send_bin(bin_of(1, 0, 1'b0));
    send_bin(bin_of(0, -1, 1'b0));
    send_bin(bin_of(SAMPLE_MIN, SAMPLE_MIN, 1'b0));
    send_bin(bin_of(SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    send_bin(bin_of(SAMPLE_MIN, SAMPLE_MAX, 1'b0));
    send_bin(bin_of(4096, -4096, 1'b0));
    send_bin(bin_of(100, -100, 1'b1));
    // frame closed on its very first bin
    send_bin(bin_of(0, 0, 1'b1));
    send_bin(bin_of(5, -5, 1'b1));
    // last_bin exactly on a group boundary, then inside a group
    set_levels(7'd2, 16'(OFFSET_AFTER_RESET));
    send_bin(bin_of(7, 0, 1'b0));
    send_bin(bin_of(0, 7, 1'b1));
    set_levels(7'd3, 16'(OFFSET_AFTER_RESET));
    send_bin(bin_of(1, 1, 1'b0));
    send_bin(bin_of(1, 1, 1'b1));
    // offset extremes: clamp high, clamp low
    set_levels(7'd1, 16'sh7FFF);
    send_bin(bin_of(1, 0, 1'b1));
    set_levels(7'd1, 16'sh8000);
    send_bin(bin_of(SAMPLE_MAX, 0, 1'b0));
    send_bin(bin_of(1, 0, 1'b1));
  endtask

  task automatic test_frame_full();
    // zero width acts as one bin per bar
    set_levels(7'd0, 16'(OFFSET_AFTER_RESET));
    for (int i = 0; i < BAR_COUNT; i++) begin
      send_bin(random_bin(1'b0));
      if (i == BAR_COUNT / 2) begin
        bins_idle();
        wait_bars_drained();
      end
    end
    // frame is full: these are dropped, and the last_bin only rearms
    repeat (3) send_bin(random_bin(1'b0));
    send_bin(random_bin(1'b1));
    random_sent += BAR_COUNT + 4;
    set_levels(7'd1, -16'sd20000);
    steady = 1'b1;
    for (int i = 0; i < BAR_COUNT; i++) send_bin(random_bin(i == BAR_COUNT - 1));
    steady = 1'b0;
    random_sent += BAR_COUNT;
  endtask

  task automatic test_random_frames();
    int len;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: set_levels(7'd127, 16'sh7FFF);
        1: set_levels(7'd64, 16'sh8000);
        2: set_levels(7'd2, 16'(OFFSET_AFTER_RESET));
        3: set_levels(7'd1, -16'sd24000);
        4: set_levels(7'(BPB_AFTER_RESET), 16'(OFFSET_AFTER_RESET));
        default: set_levels(7'($urandom_range(0, 127)), 16'($urandom()));
      endcase
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) send_bin(random_bin(i == len - 1));
      random_sent += len;
    end
  endtask

  initial begin
    bar_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      bar_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
    end
  end

  always @(posedge clk) begin
    bar_t want;
    if (bar_ch.valid === 1'b1 && bar_ch.ready === 1'b1) begin
      if (bars_due.size() == 0) begin
        $error("bar transfer with none pending: bar_index %0d", bar_ch.bar_index);
        n_fail++;
      end else begin
        want = bars_due.pop_front();
        if (bar_ch.bar_index !== want.idx) begin
          $error("bar_index: expected %0d, got %0d", want.idx, bar_ch.bar_index);
          n_fail++;
        end
        if (bar_ch.bar_level !== want.level) begin
          $error("bar_level: expected %0d, got %0d", want.level, bar_ch.bar_level);
          n_fail++;
        end
        if (bar_ch.last_bar !== want.last) begin
          $error("last_bar: expected %0d, got %0d", want.last, bar_ch.last_bar);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((bin_ch.valid === 1'b1 && bin_ch.ready === 1'b1) ||
        (bar_ch.valid === 1'b1 && bar_ch.ready === 1'b1) || cfg_psel === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("spectrum_bins_to_db_bars regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    bin_ch.valid    = 1'b0;
    bin_ch.bin_real = '0;
    bin_ch.bin_imag = '0;
    bin_ch.last_bin = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    cur_bins_per_bar = BPB_W'(BPB_AFTER_RESET);
    cur_offset       = OFFSET_W'(OFFSET_AFTER_RESET);
    acc_power        = '0;
    acc_bins         = 0;
    bars_out         = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_register_defaults();
    test_directed_bins();
    test_frame_full();
    test_random_frames();

    bins_idle();
    wait_bars_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && bars_due.size() == 0) begin
      $display("spectrum_bins_to_db_bars regression: pass");
    end else begin
      $display("spectrum_bins_to_db_bars regression: fail");
    end
    $finish;
  end

endmodule

>>> spectrum_bins_to_db_bars.f
sv/sbdb_pkg.sv
sv/sbdb_if.sv
sv/spectrum_bins_to_db_bars.sv
sim/spectrum_bins_to_db_bars_tb.sv
